### rtl/core/mcs_pkg.sv
// package for the mqtt connection supervisor: event and register codes,
// phase encoding, configuration and result structs; no dependencies
`default_nettype none
package mcs_pkg;

  // event opcodes carried on the input beat
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_TCP_RESULT = 3'd1,
    OP_CONNACK    = 3'd2,
    OP_SUBACK     = 3'd3,
    OP_PINGRESP   = 3'd4,
    OP_SEND_FAIL  = 3'd5,
    OP_LINK_ERROR = 3'd6,
    OP_RESERVED   = 3'd7
  } op_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ACK_TIMEOUT   = 3'd0,
    REG_PING_INTERVAL = 3'd1,
    REG_PUB_INTERVAL  = 3'd2,
    REG_PUB_ENABLE    = 3'd3,
    REG_SUB_ENABLE    = 3'd4,
    REG_RETRY_DELAY   = 3'd5,
    REG_BACKOFF_INIT  = 3'd6,
    REG_BACKOFF_LIMIT = 3'd7
  } reg_idx_t;

  // connection phases, one-hot
  typedef enum logic [5:0] {
    PH_RETRY     = 6'b000001,
    PH_TCP       = 6'b000010,
    PH_CONNACK   = 6'b000100,
    PH_SUBACK    = 6'b001000,
    PH_CONNECTED = 6'b010000,
    PH_BACKOFF   = 6'b100000
  } phase_t;

  // link state codes reported with each result
  localparam logic [1:0] LINK_DOWN       = 2'd0;
  localparam logic [1:0] LINK_CONNECTING = 2'd1;
  localparam logic [1:0] LINK_UP         = 2'd2;

  localparam logic [1:0]  MISS_LIMIT   = 2'd3;
  localparam logic [15:0] TIMER_MAX    = 16'hFFFF;
  localparam logic [7:0]  CODE_OK      = 8'd0;

  // register reset values
  localparam logic [15:0] RST_ACK_TIMEOUT   = 16'd5000;
  localparam logic [15:0] RST_PING_INTERVAL = 16'd40000;
  localparam logic [15:0] RST_PUB_INTERVAL  = 16'd10000;
  localparam logic        RST_PUB_ENABLE    = 1'b1;
  localparam logic        RST_SUB_ENABLE    = 1'b1;
  localparam logic [15:0] RST_RETRY_DELAY   = 16'd3000;
  localparam logic [15:0] RST_BACKOFF_INIT  = 16'd5000;
  localparam logic [15:0] RST_BACKOFF_LIMIT = 16'd60000;

  typedef struct packed {
    logic [15:0] ack_timeout;
    logic [15:0] ping_interval;
    logic [15:0] pub_interval;
    logic        pub_enable;
    logic        sub_enable;
    logic [15:0] retry_delay;
    logic [15:0] backoff_init;
    logic [15:0] backoff_limit;
  } cfg_t;

  typedef struct packed {
    logic        do_tcp_connect;
    logic        do_send_connect;
    logic        do_send_subscribe;
    logic        do_send_pingreq;
    logic        do_publish;
    logic        do_send_disconnect;
    logic        do_tcp_close;
    logic [15:0] subscribe_id;
    logic [1:0]  link_state;
    logic [1:0]  missed_pings;
  } res_t;

endpackage
`default_nettype wire

### rtl/core/mqtt_connection_supervisor_unit.sv
// mqtt connection supervisor, top level: input register, engine, result register
// a beat is held in the input register, and its result is registered for out_*
// throughput: one event per cycle; the input register moves whenever the
// result register is empty or being drained in the same cycle
// reset: synchronous active-low rst_n clears both stages and the supervisor
// state and loads the register defaults; depends on mcs_pkg, mcs_cfg_regs, mcs_engine
`default_nettype none
module mqtt_connection_supervisor_unit
  import mcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] event_code
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] do_tcp_connect, [1] do_send_connect, [2] do_send_subscribe,
  // [3] do_send_pingreq, [4] do_publish, [5] do_send_disconnect,
  // [6] do_tcp_close, [22:7] subscribe_id, [24:23] link_state,
  // [26:25] missed_pings, [31:27] zero
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t        cfg;
  res_t        res;
  logic        s1_valid_r;
  logic [2:0]  s1_op_r;
  logic [7:0]  s1_code_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        advance;
  logic        fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  mcs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mcs_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .opcode     (s1_op_r),
    .event_code (s1_code_r),
    .cfg        (cfg),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_code_r <= in_tdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {5'd0, res.missed_pings, res.link_state, res.subscribe_id,
                     res.do_tcp_close, res.do_send_disconnect, res.do_publish,
                     res.do_send_pingreq, res.do_send_subscribe,
                     res.do_send_connect, res.do_tcp_connect};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### rtl/core/mcs_cfg_regs.sv
// configuration register file behind the apb-style port
// depends on mcs_pkg for register indexes, reset values and cfg_t
`default_nettype none
module mcs_cfg_regs
  import mcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_timeout   <= RST_ACK_TIMEOUT;
      cfg_r.ping_interval <= RST_PING_INTERVAL;
      cfg_r.pub_interval  <= RST_PUB_INTERVAL;
      cfg_r.pub_enable    <= RST_PUB_ENABLE;
      cfg_r.sub_enable    <= RST_SUB_ENABLE;
      cfg_r.retry_delay   <= RST_RETRY_DELAY;
      cfg_r.backoff_init  <= RST_BACKOFF_INIT;
      cfg_r.backoff_limit <= RST_BACKOFF_LIMIT;
    end else if (wr_en) begin
      case (idx)
        REG_ACK_TIMEOUT:   cfg_r.ack_timeout   <= pwdata[15:0];
        REG_PING_INTERVAL: cfg_r.ping_interval <= pwdata[15:0];
        REG_PUB_INTERVAL:  cfg_r.pub_interval  <= pwdata[15:0];
        REG_PUB_ENABLE:    cfg_r.pub_enable    <= pwdata[0];
        REG_SUB_ENABLE:    cfg_r.sub_enable    <= pwdata[0];
        REG_RETRY_DELAY:   cfg_r.retry_delay   <= pwdata[15:0];
        REG_BACKOFF_INIT:  cfg_r.backoff_init  <= pwdata[15:0];
        REG_BACKOFF_LIMIT: cfg_r.backoff_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ACK_TIMEOUT:   prdata = {16'd0, cfg_r.ack_timeout};
      REG_PING_INTERVAL: prdata = {16'd0, cfg_r.ping_interval};
      REG_PUB_INTERVAL:  prdata = {16'd0, cfg_r.pub_interval};
      REG_PUB_ENABLE:    prdata = {31'd0, cfg_r.pub_enable};
      REG_SUB_ENABLE:    prdata = {31'd0, cfg_r.sub_enable};
      REG_RETRY_DELAY:   prdata = {16'd0, cfg_r.retry_delay};
      REG_BACKOFF_INIT:  prdata = {16'd0, cfg_r.backoff_init};
      REG_BACKOFF_LIMIT: prdata = {16'd0, cfg_r.backoff_limit};
      default:           prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/mcs_engine.sv
// supervisor state and next-state logic for one event beat
// depends on mcs_pkg for phases, opcodes, cfg_t and res_t
`default_nettype none
module mcs_engine
  import mcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [2:0] opcode,
  input  wire logic [7:0] event_code,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic [15:0] ping_r, ping_nxt;
  logic [15:0] pub_r, pub_nxt;
  logic        outst_r, outst_nxt;
  logic [1:0]  miss_r, miss_nxt;
  logic [15:0] backoff_r, backoff_nxt;
  logic [15:0] pkt_r, pkt_nxt;

  op_t         op;
  logic        wait_done;
  logic [15:0] wait_dec;
  logic [16:0] twice;
  logic [15:0] backoff_cap;
  logic [15:0] ping_inc, pub_inc;
  logic [15:0] pkt_inc;
  logic        ping_hit, pub_hit, third_miss;
  logic        do_fail, do_end, do_enter;
  logic        r_tcp, r_conn, r_sub, r_ping, r_pub, r_disc;

  assign op        = op_t'(opcode);
  assign wait_done = (wait_r <= 16'd1);
  assign wait_dec  = wait_r - 16'd1;
  assign twice     = {backoff_r, 1'b0};
  assign backoff_cap = (twice > {1'b0, cfg.backoff_limit}) ? cfg.backoff_limit
                                                           : twice[15:0];
  assign ping_inc  = (ping_r == TIMER_MAX) ? ping_r : ping_r + 16'd1;
  assign pub_inc   = (pub_r == TIMER_MAX) ? pub_r : pub_r + 16'd1;
  assign ping_hit  = (ping_inc >= cfg.ping_interval);
  assign pub_hit   = (pub_inc >= cfg.pub_interval);
  assign third_miss = ping_hit && outst_r && (miss_r == MISS_LIMIT - 2'd1);
  // packet id wraps past zero to one
  assign pkt_inc   = (pkt_r == TIMER_MAX) ? 16'd1 : pkt_r + 16'd1;

  // decide the transition for this event
  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    ping_nxt  = ping_r;
    pub_nxt   = pub_r;
    outst_nxt = outst_r;
    miss_nxt  = miss_r;
    pkt_nxt   = pkt_r;
    do_fail   = 1'b0;
    do_end    = 1'b0;
    do_enter  = 1'b0;
    r_tcp     = 1'b0;
    r_conn    = 1'b0;
    r_sub     = 1'b0;
    r_ping    = 1'b0;
    r_pub     = 1'b0;
    r_disc    = 1'b0;
    case (phase_r)
      PH_TCP: begin
        if (op == OP_TCP_RESULT) begin
          if (event_code == CODE_OK) begin
            r_conn    = 1'b1;
            phase_nxt = PH_CONNACK;
            wait_nxt  = cfg.ack_timeout;
          end else begin
            do_fail = 1'b1;
          end
        end else if (op == OP_LINK_ERROR) begin
          do_fail = 1'b1;
        end
      end
      PH_CONNACK: begin
        if (op == OP_TICK) begin
          if (wait_done) do_fail = 1'b1;
          else wait_nxt = wait_dec;
        end else if (op == OP_CONNACK) begin
          if (event_code != CODE_OK) begin
            do_fail = 1'b1;
          end else if (cfg.sub_enable) begin
            pkt_nxt   = pkt_inc;
            r_sub     = 1'b1;
            phase_nxt = PH_SUBACK;
            wait_nxt  = cfg.ack_timeout;
          end else begin
            do_enter = 1'b1;
          end
        end else if (op == OP_SEND_FAIL || op == OP_LINK_ERROR) begin
          do_fail = 1'b1;
        end
      end
      PH_SUBACK: begin
        if (op == OP_TICK) begin
          if (wait_done) do_enter = 1'b1;
          else wait_nxt = wait_dec;
        end else if (op == OP_SUBACK) begin
          do_enter = 1'b1;
        end else if (op == OP_SEND_FAIL || op == OP_LINK_ERROR) begin
          do_fail = 1'b1;
        end
      end
      PH_CONNECTED: begin
        if (op == OP_TICK) begin
          ping_nxt = ping_inc;
          pub_nxt  = pub_inc;
          if (third_miss) begin
            // keepalive lost: disconnect, no ping or publish this beat
            miss_nxt = MISS_LIMIT;
            r_disc   = 1'b1;
            do_end   = 1'b1;
          end else begin
            if (ping_hit) begin
              if (outst_r) miss_nxt = miss_r + 2'd1;
              r_ping    = 1'b1;
              outst_nxt = 1'b1;
              ping_nxt  = 16'd0;
            end
            if (pub_hit) begin
              r_pub   = cfg.pub_enable;
              pub_nxt = 16'd0;
            end
          end
        end else if (op == OP_PINGRESP) begin
          outst_nxt = 1'b0;
          miss_nxt  = 2'd0;
        end else if (op == OP_SEND_FAIL || op == OP_LINK_ERROR) begin
          do_end = 1'b1;
        end
      end
      PH_RETRY, PH_BACKOFF: begin
        if (op == OP_TICK) begin
          if (wait_done) begin
            r_tcp     = 1'b1;
            phase_nxt = PH_TCP;
          end else begin
            wait_nxt = wait_dec;
          end
        end
      end
      default: begin
        phase_nxt = PH_RETRY;
        wait_nxt  = 16'd0;
      end
    endcase

    // shared exits
    backoff_nxt = backoff_r;
    if (do_fail) begin
      phase_nxt = PH_RETRY;
      wait_nxt  = cfg.retry_delay;
    end
    if (do_end) begin
      phase_nxt   = PH_BACKOFF;
      wait_nxt    = backoff_r;
      backoff_nxt = backoff_cap;
    end
    if (do_enter) begin
      phase_nxt   = PH_CONNECTED;
      ping_nxt    = 16'd0;
      pub_nxt     = 16'd0;
      miss_nxt    = 2'd0;
      outst_nxt   = 1'b0;
      backoff_nxt = cfg.backoff_init;
    end
  end

  // result fields for this beat
  always_comb begin
    res.do_tcp_connect     = r_tcp;
    res.do_send_connect    = r_conn;
    res.do_send_subscribe  = r_sub;
    res.do_send_pingreq    = r_ping;
    res.do_publish         = r_pub;
    res.do_send_disconnect = r_disc;
    res.do_tcp_close       = do_fail | do_end;
    res.subscribe_id       = pkt_nxt;
    res.missed_pings       = miss_nxt;
    case (phase_nxt)
      PH_CONNECTED:                   res.link_state = LINK_UP;
      PH_TCP, PH_CONNACK, PH_SUBACK:  res.link_state = LINK_CONNECTING;
      default:                        res.link_state = LINK_DOWN;
    endcase
  end

  // state registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RETRY;
      wait_r    <= 16'd0;
      ping_r    <= 16'd0;
      pub_r     <= 16'd0;
      outst_r   <= 1'b0;
      miss_r    <= 2'd0;
      backoff_r <= RST_BACKOFF_INIT;
      pkt_r     <= 16'd0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      wait_r    <= wait_nxt;
      ping_r    <= ping_nxt;
      pub_r     <= pub_nxt;
      outst_r   <= outst_nxt;
      miss_r    <= miss_nxt;
      backoff_r <= backoff_nxt;
      pkt_r     <= pkt_nxt;
    end
  end

endmodule
`default_nettype wire

### bench/mqtt_connection_supervisor_unit_tb.sv
// self-checking bench for mqtt_connection_supervisor_unit: directed event table, then
// phase-aware random events under three stall profiles
// depends on mcs_pkg and the supervisor rtl
`default_nettype none
module mqtt_connection_supervisor_unit_tb;
  import mcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_REPORTED = 10;

  // request masks in result field order: tcp connect first, tcp close last
  localparam logic [6:0] REQ_NONE        = 7'b0000000;
  localparam logic [6:0] REQ_TCP_CONNECT = 7'b1000000;
  localparam logic [6:0] REQ_CONNECT     = 7'b0100000;
  localparam logic [6:0] REQ_SUBSCRIBE   = 7'b0010000;
  localparam logic [6:0] REQ_TCP_CLOSE   = 7'b0000001;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] event_code
  logic [2:0]  in_tuser = '0;   // [2:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [6:0] request flags, [22:7] subscribe_id, [24:23] link_state, [26:25] missed_pings
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mqtt_connection_supervisor_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // supervisor shadow state and register copy
  cfg_t        sup_cfg;
  phase_t      link_phase;
  logic [15:0] wait_left_ms;
  logic [15:0] ping_age_ms;
  logic [15:0] pub_age_ms;
  logic        ping_pending;
  logic [1:0]  miss_cnt;
  logic [15:0] backoff_ms;
  logic [15:0] pkt_id;
  res_t        step_req;

  res_t        awaited_reports[$];
  int unsigned mismatches = 0;
  int unsigned beat_no = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 50;

  // directed table rows: either an event beat or a register write
  typedef struct packed {
    logic        is_write;
    op_t         op;
    logic [7:0]  code;
    reg_idx_t    idx;
    logic [15:0] val;
    logic        typed;
    res_t        exp;
  } step_row_t;

  step_row_t steps[$];

  // shadow model helpers
  function automatic logic wait_over();
    if (wait_left_ms <= 16'd1) return 1'b1;
    wait_left_ms = wait_left_ms - 16'd1;
    return 1'b0;
  endfunction

  function automatic void drop_to_retry();
    step_req.do_tcp_close = 1'b1;
    link_phase = PH_RETRY;
    wait_left_ms = sup_cfg.retry_delay;
  endfunction

  function automatic void drop_to_backoff();
    logic [16:0] twice;
    twice = {backoff_ms, 1'b0};
    step_req.do_tcp_close = 1'b1;
    link_phase = PH_BACKOFF;
    wait_left_ms = backoff_ms;
    backoff_ms = (twice > {1'b0, sup_cfg.backoff_limit}) ? sup_cfg.backoff_limit : twice[15:0];
  endfunction

  function automatic void enter_session();
    link_phase = PH_CONNECTED;
    ping_age_ms = '0;
    pub_age_ms = '0;
    miss_cnt = '0;
    ping_pending = 1'b0;
    backoff_ms = sup_cfg.backoff_init;
  endfunction

  // advance the shadow supervisor by one event and return the report it raises
  function automatic res_t step_supervisor(op_t op, logic [7:0] code);
    logic ended;
    step_req = '0;
    ended = 1'b0;
    case (link_phase)
      PH_TCP: begin
        if (op == OP_TCP_RESULT && code == CODE_OK) begin
          step_req.do_send_connect = 1'b1;
          link_phase = PH_CONNACK;
          wait_left_ms = sup_cfg.ack_timeout;
        end else if (op == OP_TCP_RESULT || op == OP_LINK_ERROR) begin
          drop_to_retry();
        end
      end
      PH_CONNACK: begin
        if (op == OP_TICK) begin
          if (wait_over()) drop_to_retry();
        end else if (op == OP_CONNACK && code == CODE_OK) begin
          if (sup_cfg.sub_enable) begin
            pkt_id = pkt_id + 16'd1;
            if (pkt_id == '0) pkt_id = 16'd1;
            step_req.do_send_subscribe = 1'b1;
            link_phase = PH_SUBACK;
            wait_left_ms = sup_cfg.ack_timeout;
          end else begin
            enter_session();
          end
        end else if (op == OP_CONNACK || op == OP_SEND_FAIL || op == OP_LINK_ERROR) begin
          drop_to_retry();
        end
      end
      PH_SUBACK: begin
        if (op == OP_TICK) begin
          if (wait_over()) enter_session();
        end else if (op == OP_SUBACK) begin
          enter_session();
        end else if (op == OP_SEND_FAIL || op == OP_LINK_ERROR) begin
          drop_to_retry();
        end
      end
      PH_CONNECTED: begin
        if (op == OP_TICK) begin
          if (ping_age_ms != TIMER_MAX) ping_age_ms = ping_age_ms + 16'd1;
          if (pub_age_ms != TIMER_MAX) pub_age_ms = pub_age_ms + 16'd1;
          // keepalive first; the third unanswered interval ends the session
          if (ping_age_ms >= sup_cfg.ping_interval) begin
            if (ping_pending && miss_cnt >= MISS_LIMIT - 2'd1) begin
              miss_cnt = MISS_LIMIT;
              step_req.do_send_disconnect = 1'b1;
              drop_to_backoff();
              ended = 1'b1;
            end else begin
              if (ping_pending) miss_cnt = miss_cnt + 2'd1;
              step_req.do_send_pingreq = 1'b1;
              ping_pending = 1'b1;
              ping_age_ms = '0;
            end
          end
          if (!ended && pub_age_ms >= sup_cfg.pub_interval) begin
            step_req.do_publish = sup_cfg.pub_enable;
            pub_age_ms = '0;
          end
        end else if (op == OP_PINGRESP) begin
          ping_pending = 1'b0;
          miss_cnt = '0;
        end else if (op == OP_SEND_FAIL || op == OP_LINK_ERROR) begin
          drop_to_backoff();
        end
      end
      PH_RETRY, PH_BACKOFF: begin
        if (op == OP_TICK) begin
          if (wait_over()) begin
            step_req.do_tcp_connect = 1'b1;
            link_phase = PH_TCP;
          end
        end
      end
      default: begin
        link_phase = PH_RETRY;
        wait_left_ms = '0;
      end
    endcase
    step_req.subscribe_id = pkt_id;
    if (link_phase == PH_CONNECTED) step_req.link_state = LINK_UP;
    else if (link_phase == PH_TCP || link_phase == PH_CONNACK || link_phase == PH_SUBACK)
      step_req.link_state = LINK_CONNECTING;
    else step_req.link_state = LINK_DOWN;
    step_req.missed_pings = miss_cnt;
    return step_req;
  endfunction

  // mostly the event the current phase is waiting for, the rest noise
  function automatic void draw_event(output op_t op, output logic [7:0] code);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    op = op_t'($urandom_range(0, 7));
    code = 8'($urandom_range(0, 255));
    case (link_phase)
      PH_RETRY, PH_BACKOFF: begin
        if (roll < 90) op = OP_TICK;
      end
      PH_TCP: begin
        if (roll < 70) begin
          op = OP_TCP_RESULT;
          if ($urandom_range(0, 3) != 0) code = CODE_OK;
        end else if (roll < 80) begin
          op = OP_LINK_ERROR;
        end
      end
      PH_CONNACK: begin
        if (roll < 60) begin
          op = OP_CONNACK;
          if ($urandom_range(0, 3) != 0) code = CODE_OK;
        end else if (roll < 80) begin
          op = OP_TICK;
        end else if (roll < 90) begin
          op = (roll < 85) ? OP_SEND_FAIL : OP_LINK_ERROR;
        end
      end
      PH_SUBACK: begin
        if (roll < 50) op = OP_SUBACK;
        else if (roll < 80) op = OP_TICK;
        else if (roll < 90) op = (roll < 85) ? OP_SEND_FAIL : OP_LINK_ERROR;
      end
      PH_CONNECTED: begin
        if (roll < 75) op = OP_TICK;
        else if (roll < 87) op = OP_PINGRESP;
        else if (roll < 90) op = (roll < 89) ? OP_SEND_FAIL : OP_LINK_ERROR;
      end
      default: ;
    endcase
  endfunction

  // directed table builders
  function automatic void add_ev(op_t op, logic [7:0] code);
    step_row_t row;
    row = '0;
    row.op = op;
    row.code = code;
    steps.push_back(row);
  endfunction

  function automatic void add_chk(op_t op, logic [7:0] code, logic [6:0] req,
                                  logic [15:0] id, logic [1:0] link, logic [1:0] miss);
    step_row_t row;
    row = '0;
    row.op = op;
    row.code = code;
    row.typed = 1'b1;
    row.exp = res_t'({req, id, link, miss});
    steps.push_back(row);
  endfunction

  function automatic void add_wr(reg_idx_t idx, logic [15:0] val);
    step_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.idx = idx;
    row.val = val;
    steps.push_back(row);
  endfunction

  // one event beat; the report is predicted at the accepting edge
  task automatic send_event(op_t op, logic [7:0] code, logic typed, res_t typed_exp);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= code;
    do @(posedge clk); while (!in_tready);
    predicted = step_supervisor(op, code);
    awaited_reports.push_back(typed ? typed_exp : predicted);
  endtask

  // stop sending and wait for every awaited report
  task automatic settle_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_ACK_TIMEOUT:   sup_cfg.ack_timeout = val;
      REG_PING_INTERVAL: sup_cfg.ping_interval = val;
      REG_PUB_INTERVAL:  sup_cfg.pub_interval = val;
      REG_PUB_ENABLE:    sup_cfg.pub_enable = val[0];
      REG_SUB_ENABLE:    sup_cfg.sub_enable = val[0];
      REG_RETRY_DELAY:   sup_cfg.retry_delay = val;
      REG_BACKOFF_INIT:  sup_cfg.backoff_init = val;
      REG_BACKOFF_LIMIT: sup_cfg.backoff_limit = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] ack, logic [15:0] ping, logic [15:0] pub,
                              logic pub_en, logic sub_en, logic [15:0] retry,
                              logic [15:0] boff_init, logic [15:0] boff_limit);
    write_reg(REG_ACK_TIMEOUT, ack);
    write_reg(REG_PING_INTERVAL, ping);
    write_reg(REG_PUB_INTERVAL, pub);
    write_reg(REG_PUB_ENABLE, {15'd0, pub_en});
    write_reg(REG_SUB_ENABLE, {15'd0, sub_en});
    write_reg(REG_RETRY_DELAY, retry);
    write_reg(REG_BACKOFF_INIT, boff_init);
    write_reg(REG_BACKOFF_LIMIT, boff_limit);
  endtask

  // random events; at pause_at the sender holds off until all reports are back
  task automatic run_random(int n, int pause_at);
    op_t        op;
    logic [7:0] code;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) settle_reports();
      draw_event(op, code);
      send_event(op, code, 1'b0, '0);
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // report checker
  res_t got_report;
  res_t want_report;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_report = res_t'({out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[3],
                           out_tdata[4], out_tdata[5], out_tdata[6], out_tdata[22:7],
                           out_tdata[24:23], out_tdata[26:25]});
      beat_no++;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("report %0d unexpected: req %b id %0d link %0d miss %0d", beat_no,
                   got_report[26:20], got_report.subscribe_id, got_report.link_state,
                   got_report.missed_pings);
      end else begin
        want_report = awaited_reports.pop_front();
        if (got_report !== want_report) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("report %0d: expected req %b id %0d link %0d miss %0d, got req %b id %0d link %0d miss %0d",
                     beat_no, want_report[26:20], want_report.subscribe_id,
                     want_report.link_state, want_report.missed_pings, got_report[26:20],
                     got_report.subscribe_id, got_report.link_state,
                     got_report.missed_pings);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // shadow state after reset
    sup_cfg.ack_timeout = RST_ACK_TIMEOUT;
    sup_cfg.ping_interval = RST_PING_INTERVAL;
    sup_cfg.pub_interval = RST_PUB_INTERVAL;
    sup_cfg.pub_enable = RST_PUB_ENABLE;
    sup_cfg.sub_enable = RST_SUB_ENABLE;
    sup_cfg.retry_delay = RST_RETRY_DELAY;
    sup_cfg.backoff_init = RST_BACKOFF_INIT;
    sup_cfg.backoff_limit = RST_BACKOFF_LIMIT;
    link_phase = PH_RETRY;
    wait_left_ms = '0;
    ping_age_ms = '0;
    pub_age_ms = '0;
    ping_pending = 1'b0;
    miss_cnt = '0;
    backoff_ms = RST_BACKOFF_INIT;
    pkt_id = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset defaults, then short timings
    add_chk(OP_TICK, 8'h00, REQ_TCP_CONNECT, 16'd0, LINK_CONNECTING, 2'd0);
    add_chk(OP_RESERVED, 8'hFF, REQ_NONE, 16'd0, LINK_CONNECTING, 2'd0);
    add_chk(OP_PINGRESP, 8'h00, REQ_NONE, 16'd0, LINK_CONNECTING, 2'd0);
    add_wr(REG_RETRY_DELAY, 16'd1);
    add_wr(REG_ACK_TIMEOUT, 16'd2);
    add_wr(REG_PING_INTERVAL, 16'd2);
    add_wr(REG_PUB_INTERVAL, 16'd3);
    add_wr(REG_BACKOFF_INIT, 16'd1);
    add_wr(REG_BACKOFF_LIMIT, 16'hFFFF);
    add_wr(REG_PUB_ENABLE, 16'd1);
    add_wr(REG_SUB_ENABLE, 16'd1);
    // tcp refused
    add_chk(OP_TCP_RESULT, 8'h80, REQ_TCP_CLOSE, 16'd0, LINK_DOWN, 2'd0);
    add_chk(OP_TICK, 8'hFF, REQ_TCP_CONNECT, 16'd0, LINK_CONNECTING, 2'd0);
    add_chk(OP_TCP_RESULT, 8'h00, REQ_CONNECT, 16'd0, LINK_CONNECTING, 2'd0);
    // connack rejected
    add_chk(OP_CONNACK, 8'hFF, REQ_TCP_CLOSE, 16'd0, LINK_DOWN, 2'd0);
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_TCP_RESULT, 8'h00);
    // connack timeout
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_TCP_RESULT, 8'h00);
    add_chk(OP_CONNACK, 8'h00, REQ_SUBSCRIBE, 16'd1, LINK_CONNECTING, 2'd0);
    // rejected suback still connects
    add_chk(OP_SUBACK, 8'h80, REQ_NONE, 16'd1, LINK_UP, 2'd0);
    add_ev(OP_TICK, 8'h55);
    add_ev(OP_TICK, 8'hAA);
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_PINGRESP, 8'h00);
    add_chk(OP_SEND_FAIL, 8'h00, REQ_TCP_CLOSE, 16'd1, LINK_DOWN, 2'd0);
    add_ev(OP_LINK_ERROR, 8'h00);
    add_ev(OP_TICK, 8'h00);
    add_ev(OP_LINK_ERROR, 8'h00);

    foreach (steps[i]) begin
      if (steps[i].is_write) begin
        settle_reports();
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        send_event(steps[i].op, steps[i].code, steps[i].typed, steps[i].exp);
      end
    end

    // random: short timeouts, with one full hold-off midway
    settle_reports();
    program_regs(16'd3, 16'd4, 16'd3, 1'b1, 1'b1, 16'd2, 16'd2, 16'd9);
    run_random(440, 220);

    // random: minimum timings, no subscribe, publish off
    settle_reports();
    send_idle_pct = 50;
    recv_idle_pct = 35;
    program_regs(16'd1, 16'd1, 16'd1, 1'b0, 1'b0, 16'd1, 16'd1, 16'd1);
    run_random(440, -1);

    // random: maximum timeouts, full rate
    settle_reports();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'hFFFF, 16'd2, 16'hFFFF, 1'b1, 1'b1, 16'd1, 16'd1, 16'hFFFF);
    run_random(440, -1);

    settle_reports();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
